FILE: rtl/sha1_stream_hasher_defines.svh
// Assertion macros shared by the SHA-1 stream hasher modules.
`ifndef SHA1_STREAM_HASHER_DEFINES_SVH
`define SHA1_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define SSH_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define SSH_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ssh_pkg.sv
// Types, constants and helper functions shared by the SHA-1 stream hasher.
package ssh_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned NUM_WORDS  = 5;
  localparam int unsigned WIN_DEPTH  = 16;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [6:0] LAST_ROUND     = 7'd79;
  localparam logic [2:0] LAST_WORD_IDX  = 3'd4;
  localparam logic [5:0] BLOCK_LAST_POS = 6'd63;
  localparam logic [5:0] PAD_END_POS    = 6'd56;
  localparam logic [7:0] PAD_MARK_BYTE  = 8'h80;

  localparam logic [WORD_W-1:0] INIT_H [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

  typedef enum logic [2:0] {
    OP_NOP      = 3'd0,
    OP_PUT_BYTE = 3'd1,
    OP_LEN_HI   = 3'd2,
    OP_LEN_LO   = 3'd3,
    OP_LOAD     = 3'd4,
    OP_ROUND    = 3'd5,
    OP_ADD      = 3'd6,
    OP_EMIT     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    SEL_INPUT = 2'd0,
    SEL_MARK  = 2'd1,
    SEL_ZERO  = 2'd2
  } byte_sel_e;

  typedef struct packed {
    op_e        op;
    byte_sel_e  byte_sel;
    logic [6:0] round_idx;
    logic [2:0] word_idx;
  } cmd_t;

  typedef struct packed {
    logic [5:0] pos;
    logic       out_free;
  } status_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] round_k(input logic [6:0] t);
    if (t < 7'd20) begin
      round_k = K_0;
    end else if (t < 7'd40) begin
      round_k = K_1;
    end else if (t < 7'd60) begin
      round_k = K_2;
    end else begin
      round_k = K_3;
    end
  endfunction

endpackage

FILE: rtl/ssh_ctrl.sv
// Controller state machine: byte intake, padding, compression sequencing, digest output.
`include "sha1_stream_hasher_defines.svh"

module ssh_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  input  logic             s_axis_tuser_i,
  input  logic             s_axis_tlast_i,
  output logic             s_axis_tready_o,
  input  ssh_pkg::status_t status_i,
  output ssh_pkg::cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_PAD_MARK = 9'b000000010,
    S_PAD_ZERO = 9'b000000100,
    S_LEN_HI   = 9'b000001000,
    S_LEN_LO   = 9'b000010000,
    S_LOAD     = 9'b000100000,
    S_ROUND    = 9'b001000000,
    S_ADD      = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  state_e     ret_q, ret_d;
  logic [6:0] rnd_q, rnd_d;
  logic [2:0] idx_q, idx_d;

  always_comb begin
    state_d         = state_q;
    ret_d           = ret_q;
    rnd_d           = rnd_q;
    idx_d           = idx_q;
    s_axis_tready_o = 1'b0;
    cmd_o           = '{op: ssh_pkg::OP_NOP, byte_sel: ssh_pkg::SEL_INPUT,
                        round_idx: rnd_q, word_idx: idx_q};
    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i) begin
            cmd_o.op       = ssh_pkg::OP_PUT_BYTE;
            cmd_o.byte_sel = ssh_pkg::SEL_INPUT;
          end
          if (s_axis_tuser_i && status_i.pos == ssh_pkg::BLOCK_LAST_POS) begin
            state_d = S_LOAD;
            ret_d   = s_axis_tlast_i ? S_PAD_MARK : S_IDLE;
          end else if (s_axis_tlast_i) begin
            state_d = S_PAD_MARK;
          end
        end
      end
      S_PAD_MARK: begin
        cmd_o.op       = ssh_pkg::OP_PUT_BYTE;
        cmd_o.byte_sel = ssh_pkg::SEL_MARK;
        ret_d          = S_PAD_ZERO;
        state_d        = (status_i.pos == ssh_pkg::BLOCK_LAST_POS) ? S_LOAD : S_PAD_ZERO;
      end
      S_PAD_ZERO: begin
        if (status_i.pos == ssh_pkg::PAD_END_POS) begin
          state_d = S_LEN_HI;
        end else begin
          cmd_o.op       = ssh_pkg::OP_PUT_BYTE;
          cmd_o.byte_sel = ssh_pkg::SEL_ZERO;
          if (status_i.pos == ssh_pkg::BLOCK_LAST_POS) begin
            state_d = S_LOAD;
            ret_d   = S_PAD_ZERO;
          end
        end
      end
      S_LEN_HI: begin
        cmd_o.op = ssh_pkg::OP_LEN_HI;
        state_d  = S_LEN_LO;
      end
      S_LEN_LO: begin
        cmd_o.op = ssh_pkg::OP_LEN_LO;
        ret_d    = S_EMIT;
        state_d  = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.op = ssh_pkg::OP_LOAD;
        rnd_d    = '0;
        state_d  = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.op = ssh_pkg::OP_ROUND;
        rnd_d    = rnd_q + 7'd1;
        if (rnd_q == ssh_pkg::LAST_ROUND) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.op = ssh_pkg::OP_ADD;
        idx_d    = '0;
        state_d  = ret_q;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op = ssh_pkg::OP_EMIT;
          idx_d    = idx_q + 3'd1;
          if (idx_q == ssh_pkg::LAST_WORD_IDX) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      rnd_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
    end
  end

  `SSH_ASSERT_NEXT(a_round_end_adds, (cmd_o.op == ssh_pkg::OP_ROUND && cmd_o.round_idx == ssh_pkg::LAST_ROUND), (cmd_o.op == ssh_pkg::OP_ADD), "last round not followed by chain add")
  `SSH_ASSERT_NOW(a_len_at_pad_end, (state_q == S_LEN_HI), (status_i.pos == ssh_pkg::PAD_END_POS), "length inserted off the pad boundary")
  `SSH_ASSERT_NOW(a_emit_slot_free, (cmd_o.op == ssh_pkg::OP_EMIT), (status_i.out_free), "digest word issued into a full output register")

endmodule

FILE: rtl/ssh_datapath.sv
// Datapath: byte packing, schedule window, round unit, chaining value and output register.
`include "sha1_stream_hasher_defines.svh"

module ssh_datapath #(
  parameter int unsigned COUNT_WIDTH = 61
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ssh_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [ssh_pkg::WORD_W-1:0]     cfg_wdata_i,
  input  logic [7:0]                     in_byte_i,
  input  ssh_pkg::cmd_t                  cmd_i,
  output ssh_pkg::status_t               status_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [ssh_pkg::WORD_W-1:0]     m_axis_tdata_o,
  output logic [3:0]                     m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);

  logic [ssh_pkg::WORD_W-1:0] exp_q   [ssh_pkg::NUM_WORDS];
  logic [ssh_pkg::WORD_W-1:0] chain_q [ssh_pkg::NUM_WORDS];
  logic [ssh_pkg::WORD_W-1:0] work_q  [ssh_pkg::NUM_WORDS];
  logic [ssh_pkg::WORD_W-1:0] win_q   [ssh_pkg::WIN_DEPTH];
  logic [23:0]                partial_q;
  logic [COUNT_WIDTH-1:0]     count_q;
  logic [5:0]                 pos_q;
  logic                       m_valid_q;
  logic [ssh_pkg::WORD_W-1:0] m_data_q;
  logic [2:0]                 m_idx_q;
  logic                       m_last_q;
  logic                       m_match_q;

  logic [7:0]                 put_val;
  logic [63:0]                bit_len;
  logic                       win_shift;
  logic [ssh_pkg::WORD_W-1:0] win_new;
  logic [ssh_pkg::WORD_W-1:0] w_cur;
  logic [ssh_pkg::WORD_W-1:0] f_val;
  logic [ssh_pkg::WORD_W-1:0] temp;
  logic                       digest_eq;
  logic                       out_free;
  logic                       emit_last;

  assign bit_len   = 64'(count_q) << 3;
  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign emit_last = (cmd_i.op == ssh_pkg::OP_EMIT) && (cmd_i.word_idx == ssh_pkg::LAST_WORD_IDX);

  always_comb begin
    case (cmd_i.byte_sel)
      ssh_pkg::SEL_INPUT: put_val = in_byte_i;
      ssh_pkg::SEL_MARK:  put_val = ssh_pkg::PAD_MARK_BYTE;
      default:            put_val = 8'h00;
    endcase
  end

  // Schedule word: window rotates for the first 16 rounds, then expands
  always_comb begin
    if (cmd_i.round_idx < 7'd16) begin
      w_cur = win_q[0];
    end else begin
      w_cur = ssh_pkg::rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 1);
    end
  end

  always_comb begin
    if (cmd_i.round_idx < 7'd20) begin
      f_val = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
    end else if (cmd_i.round_idx < 7'd40) begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
    end else if (cmd_i.round_idx < 7'd60) begin
      f_val = (work_q[1] & work_q[2]) | (work_q[1] & work_q[3]) | (work_q[2] & work_q[3]);
    end else begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
    end
  end

  assign temp = ssh_pkg::rotl(work_q[0], 5) + f_val + work_q[4]
              + ssh_pkg::round_k(cmd_i.round_idx) + w_cur;

  always_comb begin
    win_shift = 1'b0;
    win_new   = w_cur;
    case (cmd_i.op)
      ssh_pkg::OP_PUT_BYTE: begin
        win_shift = (pos_q[1:0] == 2'd3);
        win_new   = {partial_q, put_val};
      end
      ssh_pkg::OP_LEN_HI: begin
        win_shift = 1'b1;
        win_new   = bit_len[63:32];
      end
      ssh_pkg::OP_LEN_LO: begin
        win_shift = 1'b1;
        win_new   = bit_len[31:0];
      end
      ssh_pkg::OP_ROUND: begin
        win_shift = 1'b1;
        win_new   = w_cur;
      end
      default: begin
        win_shift = 1'b0;
      end
    endcase
  end

  always_comb begin
    digest_eq = 1'b1;
    for (int i = 0; i < ssh_pkg::NUM_WORDS; i++) begin
      if (chain_q[i] != exp_q[i]) begin
        digest_eq = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_shift) begin
      for (int i = 0; i < ssh_pkg::WIN_DEPTH - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[ssh_pkg::WIN_DEPTH-1] <= win_new;
    end
    if (cmd_i.op == ssh_pkg::OP_PUT_BYTE) begin
      partial_q <= {partial_q[15:0], put_val};
    end
    case (cmd_i.op)
      ssh_pkg::OP_LOAD: begin
        for (int i = 0; i < ssh_pkg::NUM_WORDS; i++) begin
          work_q[i] <= chain_q[i];
        end
      end
      ssh_pkg::OP_ROUND: begin
        work_q[0] <= temp;
        work_q[1] <= work_q[0];
        work_q[2] <= ssh_pkg::rotl(work_q[1], 30);
        work_q[3] <= work_q[2];
        work_q[4] <= work_q[3];
      end
      default: begin
      end
    endcase
    if (cmd_i.op == ssh_pkg::OP_EMIT) begin
      m_data_q  <= chain_q[cmd_i.word_idx];
      m_idx_q   <= cmd_i.word_idx;
      m_last_q  <= emit_last;
      m_match_q <= emit_last && digest_eq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ssh_pkg::NUM_WORDS; i++) begin
        exp_q[i]   <= '0;
        chain_q[i] <= ssh_pkg::INIT_H[i];
      end
      count_q   <= '0;
      pos_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      for (int i = 0; i < ssh_pkg::NUM_WORDS; i++) begin
        if (cfg_we_i && cfg_addr_i == ssh_pkg::CFG_ADDR_W'(i)) begin
          exp_q[i] <= cfg_wdata_i;
        end
      end
      case (cmd_i.op)
        ssh_pkg::OP_PUT_BYTE: begin
          pos_q <= pos_q + 6'd1;
          if (cmd_i.byte_sel == ssh_pkg::SEL_INPUT) begin
            count_q <= count_q + COUNT_WIDTH'(1);
          end
        end
        ssh_pkg::OP_LEN_LO: begin
          pos_q <= '0;
        end
        ssh_pkg::OP_ADD: begin
          for (int i = 0; i < ssh_pkg::NUM_WORDS; i++) begin
            chain_q[i] <= chain_q[i] + work_q[i];
          end
        end
        ssh_pkg::OP_EMIT: begin
          if (emit_last) begin
            for (int i = 0; i < ssh_pkg::NUM_WORDS; i++) begin
              chain_q[i] <= ssh_pkg::INIT_H[i];
            end
            count_q <= '0;
            pos_q   <= '0;
          end
        end
        default: begin
        end
      endcase
      if (cmd_i.op == ssh_pkg::OP_EMIT) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.pos      = pos_q;
  assign status_o.out_free = out_free;

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = {m_match_q, m_idx_q};
  assign m_axis_tlast_o  = m_last_q;

  `SSH_ASSERT_NEXT(a_chain_reinit, (emit_last), (chain_q[0] == ssh_pkg::INIT_H[0] && pos_q == 6'd0), "chaining value not reinitialized after digest")

endmodule

FILE: rtl/sha1_stream_hasher.sv
// SHA-1 stream hasher: one message byte per input transaction, 80 rounds at one round per cycle.
// Input ready is high only while the block is idle, so no byte is taken during a compression.
// The byte that completes a 64-byte block starts a compression (load, 80 rounds through the
// single round unit, chain add). A transaction marked last then inserts the 0x80 pad byte and
// zero bytes one per cycle, unless a compression holds them, up to byte 56 of the block (with a
// further compression if the pad spills into a new block), then the 64-bit bit length as a high
// and a low word, the final compression and the five digest words, which leave on the output
// port most significant first; output backpressure stretches that last phase. Digest word 4
// carries tlast and, in tuser, the match flag against the five expected_word registers. The
// chaining value and length counter return to their initial values after each digest, ready
// for the next message.
module sha1_stream_hasher #(
  parameter int unsigned COUNT_WIDTH = 61
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ssh_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [ssh_pkg::WORD_W-1:0]     cfg_wdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,  // [7:0] data_byte
  input  logic                           s_axis_tuser_i,  // [0] has_byte
  input  logic                           s_axis_tlast_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [ssh_pkg::WORD_W-1:0]     m_axis_tdata_o,  // [31:0] digest_word
  output logic [3:0]                     m_axis_tuser_o,  // [2:0] word_index, [3] match
  output logic                           m_axis_tlast_o
);

  ssh_pkg::cmd_t    cmd;
  ssh_pkg::status_t status;

  ssh_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tready_o (s_axis_tready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  ssh_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_byte_i       (s_axis_tdata_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
